// ===== rtl/chm_pkg.sv =====
// Shared types and constants for the chained hash map.
package chm_pkg;

    // Request codes.
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_GET   = 2'd1;
    localparam logic [1:0] REQ_DEL   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Fixed field widths.
    localparam int KEY_W = 64;
    localparam int CNT_W = 11;
    localparam int DEL_W = 32;

    // Smallest legal bucket count.
    localparam logic [CNT_W-1:0] MIN_BUCKETS = 11'd11;

    // Dividend bits retired per cycle by the modulo unit.
    localparam int DIV_BITS = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_req;
        logic div_start;
        logic head_rd;
        logic walk_init;
        logic entry_rd;
        logic walk_adv;
        logic mark_hit;
        logic free_rd;
        logic put_new;
        logic resolve;
        logic clear_start;
        logic clr_start;
        logic clr_step;
        logic load_out;
    } chm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_req;
        logic [1:0] req;
        logic       div_done;
        logic       chain_end;
        logic       key_match;
        logic       pool_full;
        logic       clr_done;
        logic       out_free;
    } chm_sts_t;

endpackage

// ===== rtl/chm_mod.sv =====
// Iterative 64-bit by 11-bit modulo unit, DIV_BITS quotient bits per cycle.
module chm_mod (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [chm_pkg::KEY_W-1:0] dividend,
    input  logic [chm_pkg::CNT_W-1:0] divisor,
    output logic                     done,
    output logic [chm_pkg::CNT_W-1:0] rem
);
    import chm_pkg::*;

    localparam int STEPS  = KEY_W / DIV_BITS;
    localparam int STEP_W = $clog2(STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [KEY_W-1:0]  num_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W:0]    trial;

    // Restoring steps, one per dividend bit, most significant first.
    always_comb
    begin
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {rem_next, num_reg[KEY_W-1-i]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[CNT_W-1:0];
        end
    end

    // Sequencing of the shared step logic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend shift and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << DIV_BITS;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/chm_dp.sv =====
// Datapath of the hash map: table memories, chain walk registers and counters.
module chm_dp #(
    parameter int MAX_BUCKETS  = 1024,
    parameter int POOL_ENTRIES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  chm_pkg::chm_cmd_t         cmd,
    output chm_pkg::chm_sts_t         sts,
    input  logic                      cfg_we,
    input  logic [chm_pkg::CNT_W-1:0] cfg_wdata,
    input  logic [1:0]                req_type,
    input  logic [chm_pkg::KEY_W-1:0] key,
    input  logic [chm_pkg::KEY_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic                      inserted,
    output logic                      table_full,
    output logic [chm_pkg::KEY_W-1:0] read_value,
    output logic [chm_pkg::CNT_W-1:0] live_entries,
    output logic [chm_pkg::DEL_W-1:0] delete_total
);
    import chm_pkg::*;

    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int LW = $clog2(POOL_ENTRIES + 1);

    // Memories. Head and link entries carry a valid bit above the pointer.
    logic [PW:0]      head_mem [MAX_BUCKETS];
    logic [KEY_W-1:0] key_mem  [POOL_ENTRIES];
    logic [KEY_W-1:0] val_mem  [POOL_ENTRIES];
    logic [PW:0]      link_mem [POOL_ENTRIES];
    logic [PW-1:0]    free_mem [POOL_ENTRIES];

    logic [PW:0]      head_rd_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [KEY_W-1:0] val_rd_reg;
    logic [PW:0]      link_rd_reg;
    logic [PW-1:0]    free_rd_reg;

    // Configuration and counters.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [LW-1:0]    live_reg;
    logic [LW-1:0]    hw_reg;
    logic [DEL_W-1:0] del_reg;
    logic [BW-1:0]    clr_idx_reg;

    // Request and walk registers.
    logic [1:0]       req_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] val_reg;
    logic [BW-1:0]    bkt_reg;
    logic [PW-1:0]    cur_reg;
    logic             ok_reg;
    logic [PW-1:0]    prev_reg;
    logic             has_prev_reg;
    logic [PW-1:0]    at_reg;
    logic             hit_reg;
    logic [PW:0]      hit_link_reg;

    // Result flags and output register.
    logic             res_found_reg;
    logic             res_ins_reg;
    logic             res_full_reg;
    logic [KEY_W-1:0] res_rd_reg;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic             out_ins_reg;
    logic             out_full_reg;
    logic [KEY_W-1:0] out_rd_reg;
    logic [CNT_W-1:0] out_live_reg;
    logic [DEL_W-1:0] out_del_reg;

    logic             div_done;
    logic [CNT_W-1:0] div_rem;
    logic [PW-1:0]    new_idx;
    logic [LW-1:0]    live_inc;
    logic             head_we;
    logic [BW-1:0]    head_waddr;
    logic [PW:0]      head_wdata;
    logic             link_we;
    logic [PW-1:0]    link_waddr;
    logic [PW:0]      link_wdata;
    logic             val_we;
    logic [PW-1:0]    val_waddr;
    logic [KEY_W-1:0] val_wdata;
    logic             del_hit;
    logic             put_hit;

    chm_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (key),
        .divisor  (count_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Clamp a bucket count write into the legal range.
    always_comb
    begin
        count_next = cfg_wdata;
        if (cfg_wdata < MIN_BUCKETS)
        begin
            count_next = MIN_BUCKETS;
        end
        else if (32'(cfg_wdata) > 32'(MAX_BUCKETS))
        begin
            count_next = CNT_W'(MAX_BUCKETS);
        end
    end

    // Entry for a new key: recycled from the free stack or never used yet.
    assign new_idx  = (hw_reg > live_reg) ? free_rd_reg : PW'(live_reg);
    assign live_inc = live_reg + 1'b1;
    assign del_hit  = cmd.resolve && hit_reg && (req_reg == REQ_DEL);
    assign put_hit  = cmd.resolve && hit_reg && (req_reg == REQ_PUT);

    // Write port selection for the head, link and value memories.
    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = bkt_reg;
        head_wdata = {1'b1, new_idx};
        if (cmd.clr_step)
        begin
            head_we    = 1'b1;
            head_waddr = clr_idx_reg;
            head_wdata = '0;
        end
        else if (cmd.put_new)
        begin
            head_we = 1'b1;
        end
        else if (del_hit && !has_prev_reg)
        begin
            head_we    = 1'b1;
            head_wdata = hit_link_reg;
        end

        link_we    = 1'b0;
        link_waddr = new_idx;
        link_wdata = head_rd_reg;
        if (cmd.put_new)
        begin
            link_we = 1'b1;
        end
        else if (del_hit && has_prev_reg)
        begin
            link_we    = 1'b1;
            link_waddr = prev_reg;
            link_wdata = hit_link_reg;
        end

        val_we    = cmd.put_new || put_hit;
        val_waddr = cmd.put_new ? new_idx : at_reg;
        val_wdata = val_reg;
    end

    // Head memory.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (cmd.head_rd)
        begin
            head_rd_reg <= head_mem[bkt_reg];
        end
    end

    // Key memory.
    always_ff @(posedge clk)
    begin
        if (cmd.put_new)
        begin
            key_mem[new_idx] <= key_reg;
        end
        if (cmd.entry_rd)
        begin
            key_rd_reg <= key_mem[cur_reg];
        end
    end

    // Value memory.
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (cmd.entry_rd)
        begin
            val_rd_reg <= val_mem[cur_reg];
        end
    end

    // Link memory.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.entry_rd)
        begin
            link_rd_reg <= link_mem[cur_reg];
        end
    end

    // Free stack, indexed by the live count. Slots at or above the high-water
    // mark were never pushed and stand for the entry of the same number.
    always_ff @(posedge clk)
    begin
        if (del_hit && (live_reg != '0))
        begin
            free_mem[PW'(live_reg - 1'b1)] <= at_reg;
        end
        if (cmd.free_rd)
        begin
            free_rd_reg <= free_mem[PW'(live_reg)];
        end
    end

    // Request capture and chain walk.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            key_reg <= key;
            val_reg <= value;
        end
        if (div_done)
        begin
            bkt_reg <= BW'(div_rem);
        end
        if (cmd.walk_init)
        begin
            cur_reg      <= head_rd_reg[PW-1:0];
            ok_reg       <= head_rd_reg[PW];
            has_prev_reg <= 1'b0;
        end
        else if (cmd.walk_adv)
        begin
            prev_reg     <= cur_reg;
            has_prev_reg <= 1'b1;
            cur_reg      <= link_rd_reg[PW-1:0];
            ok_reg       <= link_rd_reg[PW];
        end
        if (cmd.mark_hit)
        begin
            at_reg       <= cur_reg;
            hit_link_reg <= link_rd_reg;
        end
    end

    // Control state of the datapath: counters, flags and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= MIN_BUCKETS;
            live_reg      <= '0;
            hw_reg        <= '0;
            del_reg       <= '0;
            clr_idx_reg   <= '0;
            req_reg       <= REQ_PUT;
            hit_reg       <= 1'b0;
            res_found_reg <= 1'b0;
            res_ins_reg   <= 1'b0;
            res_full_reg  <= 1'b0;
            res_rd_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= count_next;
            end

            // Clearing pass over the bucket heads.
            if (cmd.clr_start)
            begin
                clr_idx_reg <= '0;
                live_reg    <= '0;
                hw_reg      <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end

            if (cmd.clear_start)
            begin
                del_reg <= del_reg + DEL_W'(live_reg);
            end

            if (cmd.latch_req)
            begin
                req_reg       <= req_type;
                res_found_reg <= 1'b0;
                res_ins_reg   <= 1'b0;
                res_full_reg  <= 1'b0;
                res_rd_reg    <= '0;
            end

            if (cmd.walk_init)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.mark_hit)
            begin
                hit_reg <= 1'b1;
            end

            // Outcome of a finished walk.
            if (cmd.resolve)
            begin
                res_found_reg <= hit_reg;
                res_full_reg  <= !hit_reg && (req_reg == REQ_PUT);
                if (hit_reg && (req_reg == REQ_GET))
                begin
                    res_rd_reg <= val_rd_reg;
                end
                if (del_hit)
                begin
                    del_reg <= del_reg + 1'b1;
                    if (live_reg != '0)
                    begin
                        live_reg <= live_reg - 1'b1;
                    end
                end
            end

            if (cmd.put_new)
            begin
                res_ins_reg <= 1'b1;
                live_reg    <= live_inc;
                if (live_inc > hw_reg)
                begin
                    hw_reg <= live_inc;
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_found_reg <= res_found_reg;
            out_ins_reg   <= res_ins_reg;
            out_full_reg  <= res_full_reg;
            out_rd_reg    <= res_rd_reg;
            out_live_reg  <= CNT_W'(live_reg);
            out_del_reg   <= del_reg;
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts.in_req    = req_type;
        sts.req       = req_reg;
        sts.div_done  = div_done;
        sts.chain_end = !ok_reg;
        sts.key_match = (key_rd_reg == key_reg);
        sts.pool_full = (live_reg >= LW'(POOL_ENTRIES));
        sts.clr_done  = (clr_idx_reg == BW'(MAX_BUCKETS - 1));
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign inserted     = out_ins_reg;
    assign table_full   = out_full_reg;
    assign read_value   = out_rd_reg;
    assign live_entries = out_live_reg;
    assign delete_total = out_del_reg;

endmodule

// ===== rtl/chm_ctrl.sv =====
// Controller state machine of the hash map.
module chm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cfg_we,
    input  chm_pkg::chm_sts_t sts,
    output chm_pkg::chm_cmd_t cmd
);
    import chm_pkg::*;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_HEAD    = 4'd3;
    localparam logic [3:0] S_HWAIT   = 4'd4;
    localparam logic [3:0] S_WALK    = 4'd5;
    localparam logic [3:0] S_KCHK    = 4'd6;
    localparam logic [3:0] S_ALLOC   = 4'd7;
    localparam logic [3:0] S_RESOLVE = 4'd8;
    localparam logic [3:0] S_RESULT  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       clr_res_reg;
    logic       clr_res_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE) || cfg_we;
    assign accept   = in_valid && !in_stall;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        clr_res_next = clr_res_reg;
        cmd          = '0;
        unique case (state_reg)
            S_CLR:
            begin
                if (cfg_we)
                begin
                    cmd.clr_start = 1'b1;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                    if (sts.clr_done)
                    begin
                        state_next = clr_res_reg ? S_RESULT : S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    cmd.clr_start = 1'b1;
                    clr_res_next  = 1'b0;
                    state_next    = S_CLR;
                end
                else if (accept)
                begin
                    cmd.latch_req = 1'b1;
                    if (sts.in_req == REQ_CLEAR)
                    begin
                        cmd.clear_start = 1'b1;
                        cmd.clr_start   = 1'b1;
                        clr_res_next    = 1'b1;
                        state_next      = S_CLR;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HWAIT;
            end
            S_HWAIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (!sts.chain_end)
                begin
                    cmd.entry_rd = 1'b1;
                    state_next   = S_KCHK;
                end
                else if ((sts.req == REQ_PUT) && !sts.pool_full)
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_ALLOC;
                end
                else
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_KCHK:
            begin
                if (sts.key_match)
                begin
                    cmd.mark_hit = 1'b1;
                    state_next   = S_RESOLVE;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_WALK;
                end
            end
            S_ALLOC:
            begin
                cmd.put_new = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    clr_res_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_res_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_res_reg <= clr_res_next;
        end
    end

endmodule

// ===== rtl/chained_hash_map_u64_core.sv =====
// Top level of the chained hash map: controller, datapath and checks.
// A put, get or delete runs the iterative modulo unit that picks the bucket
// (16 steps, then the remainder is passed on), reads the bucket head, reads
// each chain entry visited and checks its key, sees the end of the chain on a
// miss, and then updates the table and loads the result. A clear, a bucket
// count write and reset each start a pass that empties the bucket heads one per
// cycle (a bucket count write during the pass starts it anew); no transaction is
// accepted during it, and a clear returns its result when it ends. One request
// is handled at a time; a result waiting in the output register does not hold
// off the next request until that request has its own result ready.
module chained_hash_map_u64_core #(
    parameter int MAX_BUCKETS  = 1024,
    parameter int POOL_ENTRIES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [chm_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic [chm_pkg::KEY_W-1:0] key,
    input  logic [chm_pkg::KEY_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic                      inserted,
    output logic                      table_full,
    output logic [chm_pkg::KEY_W-1:0] read_value,
    output logic [chm_pkg::CNT_W-1:0] live_entries,
    output logic [chm_pkg::DEL_W-1:0] delete_total
);
    import chm_pkg::*;

    chm_cmd_t cmd;
    chm_sts_t sts;

    chm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cfg_we   (cfg_we),
        .sts      (sts),
        .cmd      (cmd)
    );

    chm_dp #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_type     (req_type),
        .key          (key),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .inserted     (inserted),
        .table_full   (table_full),
        .read_value   (read_value),
        .live_entries (live_entries),
        .delete_total (delete_total)
    );

`ifndef SYNTHESIS
    // An accepted transaction keeps the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a request is in progress");

    // A full table never reports a hit or a new entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(table_full && (found || inserted)))
        else $error("table_full together with found or inserted");

    // A new entry is only made for an absent key.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(inserted && found))
        else $error("inserted together with found");

    // A result is only loaded while the controller finishes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(cmd.put_new || cmd.resolve || cmd.clr_step))
        else $error("result loaded during a table update");
`endif

endmodule
